FILE: sv/cfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRSF frame builder package
// Shared item types, frame constants and the CRC-8/DVB-S2 byte update.
// ----------------------------------------------------------------------------
package cfb_pkg;

  localparam int unsigned MaxPayload   = 60;
  localparam int unsigned CmdFifoDepth = 4;

  localparam logic [7:0] SyncByte = 8'hC8;
  localparam logic [7:0] CrcPoly  = 8'hD5;
  localparam logic [7:0] CrcMsb   = 8'h80;
  localparam logic [7:0] LenExtra = 8'd2;

  typedef struct packed {
    logic [7:0] frame_type;
    logic [5:0] pay_len;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_item_t;

  // One accepted payload byte, classified by the front end.
  typedef struct packed {
    logic       first;
    logic       last;
    logic [7:0] frame_type;
    logic [5:0] pay_len;
    logic [7:0] data_byte;
    logic [7:0] crc;
  } cmd_t;

  // CRC-8/DVB-S2, MSB first, no reflection.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcMsb) != 8'h00) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/cfb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRSF frame builder front end
// Accepts payload bytes, tracks frame position and running CRC, and
// classifies each byte into a command for the serializer.
// ----------------------------------------------------------------------------
module cfb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  cfb_pkg::in_item_t item_i,
  output logic             cmd_wr_o,
  output cfb_pkg::cmd_t    cmd_o
);

  logic       in_frame_q, in_frame_d;
  logic [5:0] bytes_left_q, bytes_left_d;
  logic [7:0] crc_q, crc_d;

  logic       len_ok;
  logic       take;
  logic [7:0] crc_base;
  logic [7:0] crc_new;
  logic [5:0] left_cur;
  logic [5:0] left_next;

  assign len_ok = (item_i.pay_len != 6'd0) &&
                  ({2'b00, item_i.pay_len} <= 8'(cfb_pkg::MaxPayload));

  // Drop a frame start with an unusable length.
  assign take = accept_i && (in_frame_q || len_ok);

  assign crc_base  = in_frame_q ? crc_q : cfb_pkg::crc8_update(8'h00, item_i.frame_type);
  assign crc_new   = cfb_pkg::crc8_update(crc_base, item_i.data_byte);
  assign left_cur  = in_frame_q ? bytes_left_q : item_i.pay_len;
  assign left_next = left_cur - 6'd1;

  always_comb begin
    in_frame_d   = in_frame_q;
    bytes_left_d = bytes_left_q;
    crc_d        = crc_q;
    if (take) begin
      if (left_next == 6'd0) begin
        in_frame_d = 1'b0;
        crc_d      = 8'h00;
      end else begin
        in_frame_d = 1'b1;
        crc_d      = crc_new;
      end
      bytes_left_d = left_next;
    end
  end

  assign cmd_wr_o          = take;
  assign cmd_o.first       = !in_frame_q;
  assign cmd_o.last        = (left_next == 6'd0);
  assign cmd_o.frame_type  = item_i.frame_type;
  assign cmd_o.pay_len     = item_i.pay_len;
  assign cmd_o.data_byte   = item_i.data_byte;
  assign cmd_o.crc         = crc_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      bytes_left_q <= 6'd0;
      crc_q        <= 8'h00;
    end else begin
      in_frame_q   <= in_frame_d;
      bytes_left_q <= bytes_left_d;
      crc_q        <= crc_d;
    end
  end

endmodule

FILE: sv/cfb_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRSF frame builder command queue
// Small FIFO that decouples the front end from the serializer.
// ----------------------------------------------------------------------------
module cfb_cmd_fifo #(
  parameter int unsigned DEPTH = cfb_pkg::CmdFifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  cfb_pkg::cmd_t wr_data_i,
  input  logic          rd_i,
  output cfb_pkg::cmd_t rd_data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cfb_pkg::cmd_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  logic do_wr, do_rd;

  assign full_o    = (count_q == CntW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

FILE: sv/cfb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRSF frame builder serializer
// Expands each command into frame bytes in an output register, one byte
// per cycle while that register is empty or being taken.
// ----------------------------------------------------------------------------
module cfb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_avail_i,
  input  cfb_pkg::cmd_t      cmd_i,
  output logic               cmd_rd_o,
  input  logic               out_take_i,
  output logic               out_valid_o,
  output cfb_pkg::out_item_t out_item_o
);

  typedef enum logic [2:0] {
    PH_START,
    PH_SYNC,
    PH_LEN,
    PH_TYPE,
    PH_DATA,
    PH_CRC
  } phase_e;

  phase_e phase_q, phase_d, phase_eff;
  logic   out_valid_q, out_valid_d;
  cfb_pkg::out_item_t out_q, out_d;
  logic   advance;

  assign advance = cmd_avail_i && (!out_valid_q || out_take_i);

  always_comb begin
    phase_eff = phase_q;
    if (phase_q == PH_START) begin
      phase_eff = cmd_i.first ? PH_SYNC : PH_DATA;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_take_i;
    out_d       = out_q;
    cmd_rd_o    = 1'b0;
    if (advance) begin
      out_valid_d     = 1'b1;
      out_d.frame_end = 1'b0;
      case (phase_eff)
        PH_SYNC: begin
          out_d.out_byte = cfb_pkg::SyncByte;
          phase_d        = PH_LEN;
        end
        PH_LEN: begin
          out_d.out_byte = {2'b00, cmd_i.pay_len} + cfb_pkg::LenExtra;
          phase_d        = PH_TYPE;
        end
        PH_TYPE: begin
          out_d.out_byte = cmd_i.frame_type;
          phase_d        = PH_DATA;
        end
        PH_DATA: begin
          out_d.out_byte = cmd_i.data_byte;
          if (cmd_i.last) begin
            phase_d = PH_CRC;
          end else begin
            phase_d  = PH_START;
            cmd_rd_o = 1'b1;
          end
        end
        PH_CRC: begin
          out_d.out_byte  = cmd_i.crc;
          out_d.frame_end = 1'b1;
          phase_d         = PH_START;
          cmd_rd_o        = 1'b1;
        end
        default: begin
          out_d.out_byte = cmd_i.data_byte;
          phase_d        = PH_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: sv/crsf_frame_builder_crc8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRSF frame builder with CRC-8/DVB-S2
// Serializes payload bytes into CRSF frames: sync, length, type, payload
// and a closing CRC over type and payload.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake          | Payload     | Transaction
//  ---------+--------------------+-------------+-----------------------------
//  input    | push / full        | in_item_i   | push && !full
//  result   | empty / pop        | out_item_o  | pop && !empty
//
// Throughput: the serializer emits one frame byte per cycle while the
// queue holds a command and pop frees the output register, so a middle
// payload byte passes at one per cycle; a frame with N payload bytes
// puts out N + 4 bytes. The header burst on the first byte is absorbed
// by the command queue, after which full stalls the input. Path: with the
// serializer idle, an accepted byte is registered in the command queue and
// then the output register before its first result shows on the result
// ports. Reset: clears frame tracking, the running CRC, queue pointers and
// the output register; no clearing pass, the first edge after release can
// take a transaction. Stalls: the output register frees as pop takes it,
// so a result waiting does not block the input until the queue fills.
// ----------------------------------------------------------------------------
module crsf_frame_builder_crc8 #(
  parameter int unsigned CMD_FIFO_DEPTH = cfb_pkg::CmdFifoDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  cfb_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output cfb_pkg::out_item_t out_item_o
);

  logic          accept;
  logic          cmd_wr;
  cfb_pkg::cmd_t cmd_wr_data;
  cfb_pkg::cmd_t cmd_head;
  logic          cmd_rd;
  logic          cmd_empty;
  logic          out_valid;

  // Accept an input transaction whenever the command queue has room; dropped
  // frame starts are accepted too but write nothing.
  assign accept = push && !full;

  cfb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .cmd_wr_o (cmd_wr),
    .cmd_o    (cmd_wr_data)
  );

  cfb_cmd_fifo #(
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_wr),
    .wr_data_i (cmd_wr_data),
    .rd_i      (cmd_rd),
    .rd_data_o (cmd_head),
    .full_o    (full),
    .empty_o   (cmd_empty)
  );

  // Hand each queued command to the serializer; it pops the entry on the
  // last byte that command produces.
  cfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_avail_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_rd_o    (cmd_rd),
    .out_take_i  (pop),
    .out_valid_o (out_valid),
    .out_item_o  (out_item_o)
  );

  assign empty = !out_valid;

endmodule
